// ===== hdl/kbd6_pkg.sv =====
// Shared types, request codes and sizes for the six-key keyboard report table.
`timescale 1ns / 1ps

package kbd6_pkg;

    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int OUT_KEYS          = 6;   // slots carried on the result channel
    localparam int KEY_W             = 8;
    localparam int REQ_W             = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SET_REPORT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PRESS       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RELEASE_ALL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd4;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // Modifier usages 0xE0..0xE7 share this upper bit pattern
    localparam logic [4:0] MOD_PREFIX = 5'h1C;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        key_t                      keycode;
        key_t                      set_modifiers;
        logic [OUT_KEYS-1:0][KEY_W-1:0] set_keys;
    } req_t;

    typedef struct packed {
        logic                      result_kind;
        key_t                      modifiers;
        logic [OUT_KEYS-1:0][KEY_W-1:0] keys;
        logic                      key_down;
    } result_t;

endpackage

// ===== hdl/keyboard_six_key_report_table.sv =====
// Top level: input register, keyboard state registers and result register.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Handshake
// -------   ---------  --------------------------------------  ---------------
// request   in         s_req_type, s_keycode, s_set_*          s_valid/s_ready
// result    out        m_result_kind, m_out_*, m_key_down      m_valid/m_ready
//
// One transaction per cycle sustained while m_ready is high; an accepted request passes
// through the input register, then the result register, before its result is presented.
// The slot compares, priority pick and state update sit between the two
// registers, and the keyboard state is written as the request moves on.
// Reset (aresetn low, synchronous) empties both registers and zeroes all state.
// A stalled result holds the request in the input register; s_ready drops
// only when both registers are full and m_ready is low.

module keyboard_six_key_report_table
    import kbd6_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_keycode,
    input  logic [7:0] s_set_modifiers,
    input  logic [7:0] s_set_key0,
    input  logic [7:0] s_set_key1,
    input  logic [7:0] s_set_key2,
    input  logic [7:0] s_set_key3,
    input  logic [7:0] s_set_key4,
    input  logic [7:0] s_set_key5,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_out_modifiers,
    output logic [7:0] m_out_key0,
    output logic [7:0] m_out_key1,
    output logic [7:0] m_out_key2,
    output logic [7:0] m_out_key3,
    output logic [7:0] m_out_key4,
    output logic [7:0] m_out_key5,
    output logic       m_key_down
);

    // Input stage
    logic    in_valid_reg, in_valid_next;
    req_t    in_req_reg;
    req_t    s_req;

    // Keyboard state
    key_t                            pressed_mods_reg,   pressed_mods_next;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] pressed_slots_reg,  pressed_slots_next;
    key_t                            reported_mods_reg,  reported_mods_next;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] reported_slots_reg, reported_slots_next;

    // Result stage
    logic    m_valid_reg, m_valid_next;
    result_t out_reg;

    logic    s_accept;
    logic    advance;
    logic    eng_valid;
    result_t eng_res;

    // Pack the request ports
    assign s_req.req_type      = s_req_type;
    assign s_req.keycode       = s_keycode;
    assign s_req.set_modifiers = s_set_modifiers;
    assign s_req.set_keys[0]   = s_set_key0;
    assign s_req.set_keys[1]   = s_set_key1;
    assign s_req.set_keys[2]   = s_set_key2;
    assign s_req.set_keys[3]   = s_set_key3;
    assign s_req.set_keys[4]   = s_set_key4;
    assign s_req.set_keys[5]   = s_set_key5;

    // The held request moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    kbd6_engine #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_engine (
        .req                (in_req_reg),
        .pressed_mods       (pressed_mods_reg),
        .pressed_slots      (pressed_slots_reg),
        .reported_mods      (reported_mods_reg),
        .reported_slots     (reported_slots_reg),
        .pressed_mods_upd   (pressed_mods_next),
        .pressed_slots_upd  (pressed_slots_next),
        .reported_mods_upd  (reported_mods_next),
        .reported_slots_upd (reported_slots_next),
        .res_valid          (eng_valid),
        .res                (eng_res)
    );

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // Undefined request types leave without producing a result transaction.
    always_comb begin
        if (advance && eng_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and keyboard state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            pressed_mods_reg   <= '0;
            pressed_slots_reg  <= '0;
            reported_mods_reg  <= '0;
            reported_slots_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                pressed_mods_reg   <= pressed_mods_next;
                pressed_slots_reg  <= pressed_slots_next;
                reported_mods_reg  <= reported_mods_next;
                reported_slots_reg <= reported_slots_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg <= s_req;
        end
        if (advance && eng_valid) begin
            out_reg <= eng_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = out_reg.result_kind;
    assign m_out_modifiers = out_reg.modifiers;
    assign m_out_key0      = out_reg.keys[0];
    assign m_out_key1      = out_reg.keys[1];
    assign m_out_key2      = out_reg.keys[2];
    assign m_out_key3      = out_reg.keys[3];
    assign m_out_key4      = out_reg.keys[4];
    assign m_out_key5      = out_reg.keys[5];
    assign m_key_down      = out_reg.key_down;

endmodule

// ===== hdl/kbd6_engine.sv =====
// Combinational request decode, slot update and result build for one transaction.
`timescale 1ns / 1ps

module kbd6_engine
    import kbd6_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
    input  req_t                             req,
    input  key_t                             pressed_mods,
    input  logic [KEY_SLOTS-1:0][KEY_W-1:0]  pressed_slots,
    input  key_t                             reported_mods,
    input  logic [KEY_SLOTS-1:0][KEY_W-1:0]  reported_slots,
    output key_t                             pressed_mods_upd,
    output logic [KEY_SLOTS-1:0][KEY_W-1:0]  pressed_slots_upd,
    output key_t                             reported_mods_upd,
    output logic [KEY_SLOTS-1:0][KEY_W-1:0]  reported_slots_upd,
    output logic                             res_valid,
    output result_t                          res
);

    logic                            is_mod;
    key_t                            mod_mask;
    logic [KEY_SLOTS-1:0]            press_ok;
    logic [KEY_SLOTS-1:0]            press_sel;
    logic [KEY_SLOTS-1:0]            pressed_hit;
    logic [KEY_SLOTS-1:0]            release_sel;
    logic [KEY_SLOTS-1:0]            reported_hit;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] set_slots;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] emit_slots;
    key_t                            emit_mods;
    logic                            down;

    assign is_mod   = (req.keycode[KEY_W-1:3] == MOD_PREFIX);
    assign mod_mask = key_t'(1) << req.keycode[2:0];

    // Per-slot compares
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            pressed_hit[i]  = (pressed_slots[i] == req.keycode);
            press_ok[i]     = (pressed_slots[i] == '0) || pressed_hit[i];
            reported_hit[i] = (reported_slots[i] == req.keycode);
        end
    end

    // Lowest qualifying slot: isolate lowest set bit
    assign press_sel   = press_ok & (~press_ok + KEY_SLOTS'(1));
    assign release_sel = pressed_hit & (~pressed_hit + KEY_SLOTS'(1));

    // Set-report slot load; slots beyond the carried ones load zero
    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_set
        if (i < OUT_KEYS) begin : g_in
            assign set_slots[i] = req.set_keys[i];
        end else begin : g_zero
            assign set_slots[i] = '0;
        end
    end

    always_comb begin
        pressed_mods_upd   = pressed_mods;
        pressed_slots_upd  = pressed_slots;
        reported_mods_upd  = reported_mods;
        reported_slots_upd = reported_slots;
        res_valid          = 1'b1;
        down               = 1'b0;
        unique case (req.req_type)
            REQ_SET_REPORT: begin
                reported_mods_upd  = req.set_modifiers;
                reported_slots_upd = set_slots;
            end
            REQ_PRESS: begin
                if (is_mod) begin
                    pressed_mods_upd = pressed_mods | mod_mask;
                end else begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (press_sel[i]) begin
                            pressed_slots_upd[i] = req.keycode;
                        end
                    end
                end
            end
            REQ_RELEASE: begin
                if (is_mod) begin
                    pressed_mods_upd = pressed_mods & ~mod_mask;
                end else begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (release_sel[i]) begin
                            pressed_slots_upd[i] = '0;
                        end
                    end
                end
            end
            REQ_RELEASE_ALL: begin
                pressed_mods_upd  = '0;
                pressed_slots_upd = '0;
            end
            REQ_QUERY: begin
                down = is_mod ? ((reported_mods & mod_mask) != '0) : (|reported_hit);
            end
            default: begin
                res_valid = 1'b0;   // undefined request: dropped
            end
        endcase
    end

    assign emit_mods  = (req.req_type == REQ_SET_REPORT) ? reported_mods_upd : pressed_mods_upd;
    assign emit_slots = (req.req_type == REQ_SET_REPORT) ? reported_slots_upd
                                                         : pressed_slots_upd;

    for (genvar j = 0; j < OUT_KEYS; j++) begin : g_out
        if (j < KEY_SLOTS) begin : g_slot
            assign res.keys[j] = (req.req_type == REQ_QUERY) ? '0 : emit_slots[j];
        end else begin : g_none
            assign res.keys[j] = '0;
        end
    end

    assign res.result_kind = (req.req_type == REQ_QUERY) ? KIND_ANSWER : KIND_REPORT;
    assign res.modifiers   = (req.req_type == REQ_QUERY) ? '0 : emit_mods;
    assign res.key_down    = down;

endmodule
